FILE: design/cra_pkg.sv
package cra_pkg;

  localparam int OWNER_W = 8;
  localparam int ADDR_W  = 10;
  localparam int COUNT_W = 10;
  localparam int END_W   = 11;
  localparam int STAT_W  = 3;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STATUS_OK       = 3'd0;
  localparam status_t STATUS_NO_TYPE  = 3'd1;
  localparam status_t STATUS_BAD_ADDR = 3'd2;
  localparam status_t STATUS_PLACED   = 3'd3;
  localparam status_t STATUS_OCCUPIED = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

FILE: design/channel_range_allocator.sv
// Contiguous channel range allocator.
// Input channel (in_valid / in_stall): one request per transfer, with owner id,
// start address and channel count. Result channel (out_valid / out_stall): one
// result per request, a status code and the end address of the requested range.
// Requests are handled one at a time by a sequencer around a single address
// counter and the slot memory's one read and one write port: it checks the
// owner's placed flag, scans the range (stops at the first taken slot), writes
// it, then loads the result. A request that fails the early checks skips the
// scan and the write and goes straight to loading its result.
// A new request is taken once the sequencer is back in idle, even while the last
// result still sits in the output register.
// After reset the block clears the slot map and the placed flags in one pass of
// a shared clear counter and stalls the input channel throughout. A stalled
// result holds; the sequencer waits with the next result until the output
// register is free.
module channel_range_allocator #(
  parameter int UNIVERSE_SIZE = 512,
  parameter int MAX_OWNERS    = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cra_pkg::OWNER_W-1:0]   in_owner_id,
  input  logic [cra_pkg::ADDR_W-1:0]    in_start_address,
  input  logic [cra_pkg::COUNT_W-1:0]   in_channel_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cra_pkg::STAT_W-1:0]    out_status,
  output logic [cra_pkg::END_W-1:0]     out_end_address
);

  localparam int AW      = $clog2(UNIVERSE_SIZE);
  localparam int CW      = $clog2(UNIVERSE_SIZE + 1);
  localparam int OWN_MAX = (MAX_OWNERS < 255) ? MAX_OWNERS : 255;
  localparam int PD      = OWN_MAX + 1;
  localparam int PW      = $clog2(PD);
  localparam int CLR_N   = (UNIVERSE_SIZE > PD) ? UNIVERSE_SIZE : PD;
  localparam int CLW     = $clog2(CLR_N);

  cra_pkg::state_t  state_r, state_nxt;
  logic [CLW-1:0]   clr_r, clr_nxt;
  logic [cra_pkg::OWNER_W-1:0] owner_r, owner_nxt;
  logic [cra_pkg::ADDR_W-1:0]  start_r, start_nxt;
  logic [cra_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [cra_pkg::END_W-1:0]   end_r, end_nxt;
  cra_pkg::status_t status_r, status_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  cra_pkg::status_t out_status_r, out_status_nxt;
  logic [cra_pkg::END_W-1:0] out_end_r, out_end_nxt;

  logic [cra_pkg::OWNER_W-1:0] slot_mem [UNIVERSE_SIZE];
  logic                        placed_mem [PD];
  logic [cra_pkg::OWNER_W-1:0] slot_rd_r;
  logic                        placed_rd_r;

  logic                        in_accept;
  logic                        slot_we;
  logic [AW-1:0]               slot_wa;
  logic [cra_pkg::OWNER_W-1:0] slot_wd;
  logic                        placed_we;
  logic [PW-1:0]               placed_wa;
  logic                        placed_wd;
  logic                        out_load;
  logic                        issue;
  logic                        occupied;
  logic                        scan_done;
  logic                        clear_done;
  logic                        owner_bad;
  cra_pkg::status_t            check_status;
  logic [AW-1:0]               first_idx;

  assign in_accept  = in_valid && !in_stall;
  assign issue      = (left_r != '0);
  assign occupied   = rd_vld_r && (slot_rd_r != '0);
  assign scan_done  = !issue && !rd_vld_r;
  assign clear_done = (clr_r == CLW'(CLR_N - 1));
  assign owner_bad  = (owner_r == '0) || (int'(owner_r) > MAX_OWNERS);
  assign first_idx  = AW'(start_r - cra_pkg::ADDR_W'(1));

  // Early checks, in priority order; a range past the map counts as occupied
  always_comb begin
    priority if (count_r == '0) begin
      check_status = cra_pkg::STATUS_NO_TYPE;
    end else if (start_r == '0 || int'(start_r) > UNIVERSE_SIZE) begin
      check_status = cra_pkg::STATUS_BAD_ADDR;
    end else if (owner_bad || placed_rd_r) begin
      check_status = cra_pkg::STATUS_PLACED;
    end else if (int'(end_r) > UNIVERSE_SIZE) begin
      check_status = cra_pkg::STATUS_OCCUPIED;
    end else begin
      check_status = cra_pkg::STATUS_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cra_pkg::ST_CLEAR:  if (clear_done) state_nxt = cra_pkg::ST_IDLE;
      cra_pkg::ST_IDLE:   if (in_accept) state_nxt = cra_pkg::ST_CHECK;
      cra_pkg::ST_CHECK: begin
        if (check_status == cra_pkg::STATUS_OK) state_nxt = cra_pkg::ST_SCAN;
        else state_nxt = cra_pkg::ST_FINISH;
      end
      cra_pkg::ST_SCAN: begin
        if (occupied) state_nxt = cra_pkg::ST_FINISH;
        else if (scan_done) state_nxt = cra_pkg::ST_WRITE;
      end
      cra_pkg::ST_WRITE:  if (left_r == CW'(1)) state_nxt = cra_pkg::ST_FINISH;
      cra_pkg::ST_FINISH: if (out_load) state_nxt = cra_pkg::ST_IDLE;
      default:            state_nxt = cra_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    slot_we   = 1'b0;
    slot_wa   = addr_r;
    slot_wd   = owner_r;
    placed_we = 1'b0;
    placed_wa = PW'(owner_r);
    placed_wd = 1'b1;
    out_load  = 1'b0;
    unique case (state_r)
      cra_pkg::ST_CLEAR: begin
        slot_we   = (int'(clr_r) < UNIVERSE_SIZE);
        slot_wa   = AW'(clr_r);
        slot_wd   = '0;
        placed_we = (int'(clr_r) < PD);
        placed_wa = PW'(clr_r);
        placed_wd = 1'b0;
      end
      cra_pkg::ST_IDLE:   in_stall = 1'b0;
      cra_pkg::ST_CHECK:  ;
      cra_pkg::ST_SCAN:   ;
      cra_pkg::ST_WRITE: begin
        slot_we   = 1'b1;
        placed_we = (left_r == CW'(1));
      end
      cra_pkg::ST_FINISH: out_load = !out_valid_r || !out_stall;
      default:            ;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    owner_nxt      = owner_r;
    start_nxt      = start_r;
    count_nxt      = count_r;
    end_nxt        = end_r;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    left_nxt       = left_r;
    rd_vld_nxt     = rd_vld_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_end_nxt    = out_end_r;

    unique case (state_r)
      cra_pkg::ST_CLEAR: clr_nxt = clr_r + CLW'(1);
      cra_pkg::ST_IDLE: begin
        if (in_accept) begin
          owner_nxt = in_owner_id;
          start_nxt = in_start_address;
          count_nxt = in_channel_count;
          end_nxt   = cra_pkg::END_W'({1'b0, in_start_address}
                      + {1'b0, in_channel_count} - cra_pkg::END_W'(1));
        end
      end
      cra_pkg::ST_CHECK: begin
        status_nxt = check_status;
        addr_nxt   = first_idx;
        left_nxt   = CW'(count_r);
        rd_vld_nxt = 1'b0;
      end
      cra_pkg::ST_SCAN: begin
        // read issued this cycle is checked the next, one slot per cycle
        rd_vld_nxt = issue;
        if (issue) begin
          addr_nxt = addr_r + AW'(1);
          left_nxt = left_r - CW'(1);
        end
        if (occupied) begin
          status_nxt = cra_pkg::STATUS_OCCUPIED;
        end else if (scan_done) begin
          addr_nxt = first_idx;
          left_nxt = CW'(count_r);
        end
      end
      cra_pkg::ST_WRITE: begin
        addr_nxt = addr_r + AW'(1);
        left_nxt = left_r - CW'(1);
      end
      cra_pkg::ST_FINISH: ;
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_end_nxt    = end_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cra_pkg::ST_CLEAR;
      clr_r       <= '0;
      left_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      left_r      <= left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r      <= owner_nxt;
    start_r      <= start_nxt;
    count_r      <= count_nxt;
    end_r        <= end_nxt;
    status_r     <= status_nxt;
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_end_r    <= out_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_r <= slot_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (placed_we) placed_mem[placed_wa] <= placed_wd;
    if (in_accept) placed_rd_r <= placed_mem[PW'(in_owner_id)];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_end_address = out_end_r;

endmodule

FILE: design/cra_checker.sv
module cra_checker #(
  parameter int UNIVERSE_SIZE = 512
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [cra_pkg::STAT_W-1:0]  out_status,
  input logic [cra_pkg::END_W-1:0]   out_end_address
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_end_address))
    else $error("stalled result changed");

  // one request at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // a granted range lies inside the map
  a_ok_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cra_pkg::STATUS_OK |->
      out_end_address != '0 && int'(out_end_address) <= UNIVERSE_SIZE)
    else $error("granted range leaves the map");

endmodule

bind channel_range_allocator cra_checker #(.UNIVERSE_SIZE(UNIVERSE_SIZE)) u_cra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_end_address (out_end_address)
);
